@@ hdl/tch_pkg.sv @@
// Shared types and constants for the TLS ClientHello extension finder.
package tch_pkg;

  // Largest message accepted; longer messages report not found.
  localparam int MAX_MESSAGE_BYTES = 131072;
  // Version plus random, after the 4-byte handshake header.
  localparam int FIXED_PREFIX = 4 + 2 + 32;
  // Byte position must also hold the count one past the last byte.
  localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
  // Skip targets reach a position plus one plus a 16-bit length.
  localparam int TGT_W = ((POS_W > 16) ? POS_W : 16) + 2;
  localparam int OFFSET_W = 17;
  localparam int LEN_W = 16;
  localparam int TYPE_W = 16;

  typedef enum logic [3:0] {
    PH_PREFIX, PH_SID_LEN, PH_SKIP_SID, PH_CS_HI, PH_CS_LO, PH_SKIP_CS,
    PH_COMP_LEN, PH_SKIP_COMP, PH_EXT_HI, PH_EXT_LO, PH_TYPE_HI,
    PH_TYPE_LO, PH_LEN_HI, PH_LEN_LO, PH_SKIP_EXT, PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] data_offset;
    logic [LEN_W-1:0]    data_length;
  } result_t;

endpackage

@@ hdl/tch_in_stage.sv @@
// Input register that holds one message byte until the parser takes it.
module tch_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tch_pkg::byte_item_t in_item,
  input  logic               advance,
  output logic               held_valid,
  output tch_pkg::byte_item_t held_item
);
  import tch_pkg::*;

  // The register frees up whenever its item moves on in the same cycle.
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

@@ hdl/tch_parser.sv @@
// Parse state registers and the per-byte next-state logic of the finder.
module tch_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  tch_pkg::byte_item_t         item,
  input  logic [tch_pkg::TYPE_W-1:0]  sought_type,
  output tch_pkg::result_t            result
);
  import tch_pkg::*;

  phase_t              phase, phase_next;
  logic [POS_W-1:0]    byte_position, byte_position_next;
  logic [TGT_W-1:0]    skip_target, skip_target_next;
  logic [TGT_W-1:0]    extensions_end, extensions_end_next;
  logic [7:0]          length_high_hold, length_high_hold_next;
  logic [TYPE_W-1:0]   type_hold, type_hold_next;
  logic                match_seen, match_seen_next;
  logic [OFFSET_W-1:0] match_offset, match_offset_next;
  logic [LEN_W-1:0]    match_length, match_length_next;
  logic                parse_failed, parse_failed_next;

  logic [TGT_W-1:0]    pos_w;
  logic [TGT_W-1:0]    pos1;
  logic [TGT_W-1:0]    len16_w;
  logic [TGT_W-1:0]    len8_w;
  logic [LEN_W-1:0]    len16;
  phase_t              ph;
  logic                ok;

  // Widened views of the current position and the byte pair lengths.
  assign pos_w   = TGT_W'(byte_position);
  assign pos1    = pos_w + TGT_W'(1);
  assign len16   = {length_high_hold, item.message_byte};
  assign len16_w = TGT_W'(len16);
  assign len8_w  = TGT_W'(item.message_byte);

  // Next state for one byte, then the result and clear on the last byte.
  always_comb begin
    phase_next            = phase;
    byte_position_next    = byte_position;
    skip_target_next      = skip_target;
    extensions_end_next   = extensions_end;
    length_high_hold_next = length_high_hold;
    type_hold_next        = type_hold;
    match_seen_next       = match_seen;
    match_offset_next     = match_offset;
    match_length_next     = match_length;
    parse_failed_next     = parse_failed;
    ph                    = phase;
    ok                    = 1'b0;
    result                = '0;

    if (!parse_failed) begin
      if (byte_position >= POS_W'(MAX_MESSAGE_BYTES)) begin
        parse_failed_next = 1'b1;
        phase_next        = PH_DONE;
      end else begin
        // Leave a skip phase once its target position is reached.
        case (phase)
          PH_SKIP_SID:  if (pos_w >= skip_target) ph = PH_CS_HI;
          PH_SKIP_CS:   if (pos_w >= skip_target) ph = PH_COMP_LEN;
          PH_SKIP_COMP: if (pos_w >= skip_target) ph = PH_EXT_HI;
          PH_SKIP_EXT:  if (pos_w >= skip_target) ph = PH_TYPE_HI;
          default:      ph = phase;
        endcase
        // Too little room left in the block for another extension header.
        if (ph == PH_TYPE_HI && (pos_w + TGT_W'(4)) > extensions_end) begin
          ph = PH_DONE;
        end
        phase_next = ph;

        unique case (ph)
          PH_PREFIX: begin
            if (pos1 >= TGT_W'(FIXED_PREFIX)) phase_next = PH_SID_LEN;
          end
          PH_SID_LEN: begin
            skip_target_next = pos1 + len8_w;
            phase_next       = PH_SKIP_SID;
          end
          PH_CS_HI: begin
            length_high_hold_next = item.message_byte;
            phase_next            = PH_CS_LO;
          end
          PH_CS_LO: begin
            skip_target_next = pos1 + len16_w;
            phase_next       = PH_SKIP_CS;
          end
          PH_COMP_LEN: begin
            skip_target_next = pos1 + len8_w;
            phase_next       = PH_SKIP_COMP;
          end
          PH_EXT_HI: begin
            length_high_hold_next = item.message_byte;
            phase_next            = PH_EXT_LO;
          end
          PH_EXT_LO: begin
            extensions_end_next = pos1 + len16_w;
            skip_target_next    = pos1;
            phase_next          = PH_SKIP_EXT;
          end
          PH_TYPE_HI: begin
            type_hold_next = {item.message_byte, 8'h00};
            phase_next     = PH_TYPE_LO;
          end
          PH_TYPE_LO: begin
            type_hold_next = {type_hold[TYPE_W-1:8], item.message_byte};
            phase_next     = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            length_high_hold_next = item.message_byte;
            phase_next            = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            if ((pos1 + len16_w) > extensions_end) begin
              parse_failed_next = 1'b1;
              phase_next        = PH_DONE;
            end else if (type_hold == sought_type) begin
              match_seen_next   = 1'b1;
              match_offset_next = pos1[OFFSET_W-1:0];
              match_length_next = len16;
              phase_next        = PH_DONE;
            end else begin
              skip_target_next = pos1 + len16_w;
              phase_next       = PH_SKIP_EXT;
            end
          end
          default: begin
          end
        endcase
        byte_position_next = byte_position + POS_W'(1);
      end
    end

    // The message ends: report, then return to the start of a message.
    if (item.last_byte) begin
      ok = match_seen_next && !parse_failed_next &&
           (extensions_end_next <= TGT_W'(byte_position_next));
      result.found       = ok;
      result.data_offset = ok ? match_offset_next : '0;
      result.data_length = ok ? match_length_next : '0;
      phase_next            = PH_PREFIX;
      byte_position_next    = '0;
      skip_target_next      = '0;
      extensions_end_next   = '0;
      length_high_hold_next = '0;
      type_hold_next        = '0;
      match_seen_next       = 1'b0;
      match_offset_next     = '0;
      match_length_next     = '0;
      parse_failed_next     = 1'b0;
    end
  end

  // State registers advance once per byte taken from the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_PREFIX;
      byte_position    <= '0;
      skip_target      <= '0;
      extensions_end   <= '0;
      length_high_hold <= '0;
      type_hold        <= '0;
      match_seen       <= 1'b0;
      match_offset     <= '0;
      match_length     <= '0;
      parse_failed     <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      byte_position    <= byte_position_next;
      skip_target      <= skip_target_next;
      extensions_end   <= extensions_end_next;
      length_high_hold <= length_high_hold_next;
      type_hold        <= type_hold_next;
      match_seen       <= match_seen_next;
      match_offset     <= match_offset_next;
      match_length     <= match_length_next;
      parse_failed     <= parse_failed_next;
    end
  end

endmodule

@@ hdl/tch_out_stage.sv @@
// Result register that holds one result item until the receiver takes it.
module tch_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  tch_pkg::result_t load_item,
  output logic             out_valid,
  input  logic             out_ready,
  output tch_pkg::result_t out_item
);
  import tch_pkg::*;

  // A load only happens when the register is empty or being emptied.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= load_item;
    end
  end

endmodule

@@ hdl/tls_client_hello_ext_finder.sv @@
// Top level of the TLS ClientHello extension finder.
//
// A ClientHello message streams in on the input channel one byte per item,
// with last_byte high on its final byte. Each message yields exactly one
// result item on the output channel, issued for its last byte: found, and
// the offset and length of the data of the first extension whose type
// equals the sought type. Other bytes give no result.
// The sought type is written through the configuration channel, which is
// always ready; it resets to 16 and keeps its value across messages.
// Throughput is one byte per cycle: the parse state is updated once per
// byte by compare and add logic between the input register and the
// state registers. The result of a last byte is loaded into the output
// register when that byte leaves the input register, and offered there.
// While a result waits, further non-final bytes are still taken; a second
// last byte waits in the input register, and the input channel stalls,
// until the pending result is taken.
// Synchronous reset empties both registers and returns to message start.
module tls_client_hello_ext_finder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tch_pkg::TYPE_W-1:0]    sought_type,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    message_byte,
  input  logic                          last_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [tch_pkg::OFFSET_W-1:0]  data_offset,
  output logic [tch_pkg::LEN_W-1:0]     data_length
);
  import tch_pkg::*;

  logic [TYPE_W-1:0] sought_reg;
  byte_item_t        in_item;
  byte_item_t        held_item;
  logic              held_valid;
  logic              advance;
  result_t           parse_result;
  result_t           out_item;

  // Configuration register for the extension type searched for.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sought_reg <= TYPE_W'(16);
    end else if (cfg_valid) begin
      sought_reg <= sought_type;
    end
  end

  assign in_item.message_byte = message_byte;
  assign in_item.last_byte    = last_byte;

  // A held byte moves on unless it would load a result into a full register.
  assign advance = held_valid && (!held_item.last_byte || !out_valid || out_ready);

  tch_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  tch_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (held_item),
    .sought_type (sought_reg),
    .result      (parse_result)
  );

  tch_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && held_item.last_byte),
    .load_item (parse_result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  assign found       = out_item.found;
  assign data_offset = out_item.data_offset;
  assign data_length = out_item.data_length;

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the TLS ClientHello extension finder.
module tb_top;
  import tch_pkg::*;

  localparam int IDLE_PCT     = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_GAP   = 4;
  localparam int DRAIN_LIMIT  = 100000;
  localparam int RANDOM_MESSAGES = 6;
  localparam logic [TYPE_W-1:0] ALPN_TYPE = 16'h0010;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [TYPE_W-1:0] sought_type;
  logic in_valid;
  logic in_ready;
  logic [7:0] message_byte;
  logic last_byte;
  logic out_valid;
  logic out_ready = 1'b0;
  logic found;
  logic [OFFSET_W-1:0] data_offset;
  logic [LEN_W-1:0] data_length;

  tls_client_hello_ext_finder i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .sought_type  (sought_type),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .message_byte (message_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .data_offset  (data_offset),
    .data_length  (data_length)
  );

  // Shared state of the stimulus side.
  result_t pending_results[$];
  logic [7:0] msg[$];
  logic [7:0] ext_body[$];
  bit calm = 1'b0;
  int hold_token = 0;
  int n_errors = 0;
  int n_checked = 0;
  int n_bytes = 0;
  int n_messages = 0;
  int n_settings = 1;

  // Predicted parser state of the block.
  logic [TYPE_W-1:0] sought_now;
  phase_t            phase;
  logic [POS_W-1:0]  pos_now;
  logic [TGT_W-1:0]  skip_target;
  logic [TGT_W-1:0]  ext_end;
  logic [7:0]        hi_hold;
  logic [TYPE_W-1:0] type_hold;
  bit                hit_seen;
  logic [OFFSET_W-1:0] hit_offset;
  logic [LEN_W-1:0]  hit_length;
  bit                parse_bad;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Return the predicted parser to the start of a message.
  function automatic void clear_parse();
    phase = PH_PREFIX;
    pos_now = '0;
    skip_target = '0;
    ext_end = '0;
    hi_hold = '0;
    type_hold = '0;
    hit_seen = 1'b0;
    hit_offset = '0;
    hit_length = '0;
    parse_bad = 1'b0;
  endfunction

  // Walk one accepted byte; returns 1 with the expected result on a last byte.
  function automatic bit walk_hello(input logic [7:0] b, input logic l, output result_t r);
    logic [TGT_W-1:0] p;
    logic [TGT_W-1:0] len;
    bit ok;
    r = '0;
    if (!parse_bad) begin
      if (pos_now >= MAX_MESSAGE_BYTES) begin
        parse_bad = 1'b1;
        phase = PH_DONE;
      end else begin
        p = TGT_W'(pos_now);
        // A finished skip falls through to the next field on this same byte.
        case (phase)
          PH_SKIP_SID:  if (p >= skip_target) phase = PH_CS_HI;
          PH_SKIP_CS:   if (p >= skip_target) phase = PH_COMP_LEN;
          PH_SKIP_COMP: if (p >= skip_target) phase = PH_EXT_HI;
          PH_SKIP_EXT:  if (p >= skip_target) phase = PH_TYPE_HI;
          default: ;
        endcase
        // Too little of the block left for another extension header.
        if (phase == PH_TYPE_HI && p + TGT_W'(4) > ext_end) phase = PH_DONE;
        case (phase)
          PH_PREFIX: if (p + TGT_W'(1) >= TGT_W'(FIXED_PREFIX)) phase = PH_SID_LEN;
          PH_SID_LEN: begin
            skip_target = p + TGT_W'(1) + TGT_W'(b);
            phase = PH_SKIP_SID;
          end
          PH_CS_HI: begin
            hi_hold = b;
            phase = PH_CS_LO;
          end
          PH_CS_LO: begin
            skip_target = p + TGT_W'(1) + TGT_W'({hi_hold, b});
            phase = PH_SKIP_CS;
          end
          PH_COMP_LEN: begin
            skip_target = p + TGT_W'(1) + TGT_W'(b);
            phase = PH_SKIP_COMP;
          end
          PH_EXT_HI: begin
            hi_hold = b;
            phase = PH_EXT_LO;
          end
          PH_EXT_LO: begin
            ext_end = p + TGT_W'(1) + TGT_W'({hi_hold, b});
            skip_target = p + TGT_W'(1);
            phase = PH_SKIP_EXT;
          end
          PH_TYPE_HI: begin
            type_hold = {b, 8'h00};
            phase = PH_TYPE_LO;
          end
          PH_TYPE_LO: begin
            type_hold[7:0] = b;
            phase = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            hi_hold = b;
            phase = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            len = TGT_W'({hi_hold, b});
            if (p + TGT_W'(1) + len > ext_end) begin
              parse_bad = 1'b1;
              phase = PH_DONE;
            end else if (type_hold == sought_now) begin
              hit_seen = 1'b1;
              hit_offset = OFFSET_W'(p + TGT_W'(1));
              hit_length = len[LEN_W-1:0];
              phase = PH_DONE;
            end else begin
              skip_target = p + TGT_W'(1) + len;
              phase = PH_SKIP_EXT;
            end
          end
          default: ;
        endcase
        pos_now = pos_now + 1'b1;
      end
    end
    if (!l) return 1'b0;
    ok = hit_seen && !parse_bad && (ext_end <= TGT_W'(pos_now));
    r.found = ok;
    r.data_offset = ok ? hit_offset : '0;
    r.data_length = ok ? hit_length : '0;
    clear_parse();
    return 1'b1;
  endfunction

  // Offer one byte, idling at random first, and predict it once accepted.
  task automatic send_byte(input logic [7:0] b, input logic l);
    result_t r;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    message_byte <= b;
    last_byte <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_bytes++;
    if (walk_hello(b, l, r)) pending_results.push_back(r);
  endtask

  // Send the built message with the last-byte mark on its final byte.
  task automatic send_msg();
    for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
    n_messages++;
    msg.delete();
  endtask

  // Stop offering bytes until every expected result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic set_sought_type(input logic [TYPE_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    sought_type <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sought_now = v;
    n_settings++;
  endtask

  // Header, version, random and the three skipped vectors.
  task automatic start_hello(input int sid_n, input int cs_n, input int comp_n);
    msg.delete();
    ext_body.delete();
    repeat (FIXED_PREFIX) msg.push_back(8'($urandom_range(0, 255)));
    msg.push_back(8'(sid_n));
    repeat (sid_n) msg.push_back(8'($urandom_range(0, 255)));
    msg.push_back(8'(cs_n >> 8));
    msg.push_back(8'(cs_n));
    repeat (cs_n) msg.push_back(8'($urandom_range(0, 255)));
    msg.push_back(8'(comp_n));
    repeat (comp_n) msg.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_ext(input logic [15:0] t, input logic [15:0] declared, input int n_data);
    ext_body.push_back(t[15:8]);
    ext_body.push_back(t[7:0]);
    ext_body.push_back(declared[15:8]);
    ext_body.push_back(declared[7:0]);
    repeat (n_data) ext_body.push_back(8'($urandom_range(0, 255)));
  endtask

  // Emit the block length (true size plus adjust) and the extensions.
  task automatic close_block(input int adjust);
    int n;
    n = ext_body.size() + adjust;
    if (n < 0) n = 0;
    msg.push_back(8'(n >> 8));
    msg.push_back(8'(n));
    foreach (ext_body[i]) msg.push_back(ext_body[i]);
    ext_body.delete();
  endtask

  task automatic add_noise(input int n);
    repeat (n) msg.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic test_default_type();
    start_hello(0, 0, 0);
    add_ext(ALPN_TYPE, 2, 2);
    close_block(0);
    send_msg();
    start_hello(255, 16'h0102, 1);
    add_ext(16'h0000, 0, 0);
    add_ext(ALPN_TYPE, 5, 5);
    close_block(0);
    send_msg();
  endtask

  task automatic test_type_extremes();
    set_sought_type(16'h0000);
    start_hello(1, 2, 1);
    add_ext(16'h0000, 0, 0);
    close_block(0);
    send_msg();
    set_sought_type(16'hFFFF);
    start_hello(32, 4, 1);
    add_ext(16'hFFFE, 3, 3);
    add_ext(16'hFFFF, 1, 1);
    close_block(0);
    send_msg();
    set_sought_type(ALPN_TYPE);
  endtask

  task automatic test_malformed();
    // Block too short for any extension header.
    start_hello(0, 2, 1);
    add_noise(0);
    repeat (3) ext_body.push_back(8'($urandom_range(0, 255)));
    close_block(0);
    send_msg();
    // A non-matching extension leaves too little of the block for another.
    start_hello(0, 2, 1);
    add_ext(16'h0001, 1, 1);
    repeat (3) ext_body.push_back(ALPN_TYPE[7:0]);
    close_block(0);
    send_msg();
    // An overrunning extension before the match.
    start_hello(0, 2, 1);
    add_ext(16'h0001, 50, 2);
    add_ext(ALPN_TYPE, 2, 2);
    close_block(0);
    send_msg();
    // An overrunning extension after the match does not matter.
    start_hello(0, 2, 1);
    add_ext(ALPN_TYPE, 2, 2);
    add_ext(16'h0002, 90, 1);
    close_block(0);
    send_msg();
    // Block length beyond the end of the message.
    start_hello(0, 2, 1);
    add_ext(ALPN_TYPE, 2, 2);
    close_block(20);
    send_msg();
    // Message ends inside the matching extension header.
    start_hello(0, 2, 1);
    add_ext(16'h0005, 1, 1);
    add_ext(ALPN_TYPE, 3, 3);
    close_block(0);
    repeat (5) void'(msg.pop_back());
    send_msg();
    // Trailing bytes after the block, and the first of two matches wins.
    start_hello(2, 2, 1);
    add_ext(ALPN_TYPE, 1, 1);
    add_ext(ALPN_TYPE, 2, 2);
    close_block(0);
    add_noise(6);
    send_msg();
    // Empty extensions block, a one-byte message, and one cut in the prefix.
    start_hello(0, 2, 1);
    close_block(0);
    send_msg();
    add_noise(1);
    send_msg();
    add_noise(20);
    send_msg();
  endtask

  // An all-ones extension length always runs past the block.
  task automatic test_length_limit();
    start_hello(0, 2, 1);
    add_ext(ALPN_TYPE, 16'hFFFF, 0);
    close_block(0);
    send_msg();
  endtask

  // The receiver holds off while short messages keep coming.
  task automatic test_backpressure();
    settle();
    hold_token <= hold_token + 1;
    repeat (3) begin
      add_noise(1);
      send_msg();
    end
    start_hello(0, 2, 1);
    add_ext(ALPN_TYPE, 1, 1);
    close_block(0);
    send_msg();
    repeat (2) begin
      add_noise(1);
      send_msg();
    end
    settle();
  endtask

  task automatic random_hello();
    int kind;
    int n_ext;
    int dl;
    int sid_n;
    logic [15:0] t;
    logic [15:0] declared;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      msg.delete();
      add_noise($urandom_range(1, 48));
    end else begin
      sid_n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
      start_hello(sid_n, $urandom_range(0, 6) * 2, $urandom_range(0, 3));
      n_ext = $urandom_range(0, 5);
      repeat (n_ext) begin
        case ($urandom_range(0, 4))
          0, 1: t = sought_now;
          2: t = sought_now ^ (16'h1 << $urandom_range(0, 15));
          3: t = 16'($urandom_range(0, 65535));
          default: t = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
        endcase
        dl = $urandom_range(0, 6);
        declared = 16'(dl);
        if (kind < 14 && $urandom_range(0, 2) == 0) declared = 16'(dl + $urandom_range(1, 40));
        add_ext(t, declared, dl);
      end
      close_block((kind >= 8 && kind < 14) ? int'($urandom_range(0, 12)) - 6 : 0);
      if (kind >= 14 && kind < 20) begin
        dl = $urandom_range(1, msg.size());
        while (msg.size() > dl) void'(msg.pop_back());
      end
      if (kind >= 20 && kind < 28) add_noise($urandom_range(1, 10));
    end
    send_msg();
  endtask

  task automatic test_random();
    int k;
    k = 0;
    while (k < RANDOM_MESSAGES) begin
      if (k % 3 == 1) begin
        case ($urandom_range(0, 3))
          0: set_sought_type(16'h0000);
          1: set_sought_type(16'hFFFF);
          default: set_sought_type(16'($urandom_range(0, 65535)));
        endcase
      end
      if (k == 2) calm <= 1'b1;
      if (k == 5) calm <= 1'b0;
      if (k == 5) settle();
      random_hello();
      k++;
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin : drive_out_ready
    int hold_seen;
    int hold_left;
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        $error("result item with no expectation waiting");
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (found !== want.found) begin
          n_errors++;
          $error("found: expected %0d, actual %0d", want.found, found);
        end
        if (data_offset !== want.data_offset) begin
          n_errors++;
          $error("data_offset: expected %0d, actual %0d", want.data_offset, data_offset);
        end
        if (data_length !== want.data_length) begin
          n_errors++;
          $error("data_length: expected %0d, actual %0d", want.data_length, data_length);
        end
      end
    end
  end

  initial begin
    #12000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    sought_type <= ALPN_TYPE;
    in_valid <= 1'b0;
    message_byte <= 8'h00;
    last_byte <= 1'b0;
    sought_now = ALPN_TYPE;
    clear_parse();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_default_type();
    test_type_extremes();
    test_malformed();
    test_backpressure();
    test_length_limit();
    test_random();

    // Drain the remaining results, then allow for the block's latency.
    in_valid <= 1'b0;
    @(posedge clk);
    for (int w = 0; w < DRAIN_LIMIT && pending_results.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      n_errors++;
      $error("%0d expected results never arrived", pending_results.size());
    end
    $display("Run covered %0d messages, %0d bytes and %0d sought-type settings.",
             n_messages, n_bytes, n_settings);
    $display("Checked %0d results, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
